@@ src/bsis_pkg.sv @@
// shared request, result and control types for the banked sorted id set
`timescale 1ns / 1ps
`default_nettype none

package bsis_pkg;

  // request kinds
  localparam logic [2:0] OP_INSERT = 3'd0;
  localparam logic [2:0] OP_DELETE = 3'd1;
  localparam logic [2:0] OP_TEST   = 3'd2;
  localparam logic [2:0] OP_COUNT  = 3'd3;
  localparam logic [2:0] OP_READ   = 3'd4;

  // one request on the input channel
  typedef struct packed {
    logic [2:0]  op;
    logic [4:0]  bank;
    logic [31:0] item_id;
    logic [3:0]  entry_index;
  } bsis_req_t;

  // one result on the output channel
  typedef struct packed {
    logic        ok;
    logic [4:0]  held_count;
    logic [31:0] entry_value;
  } bsis_rsp_t;

  // controller to datapath commands
  typedef struct packed {
    logic capture;
    logic load_n;
    logic start;
    logic finish;
  } bsis_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic scan_busy;
  } bsis_sts_t;

endpackage

`default_nettype wire

@@ src/banked_sorted_id_set.sv @@
// top level of the banked sorted id set
// Keeps one ascending sorted id list per bank (banks numbered from 1) and
// serves insert, delete, membership test, count query and read entry
// requests. Request channel: req_valid / req_stall / req, result channel:
// rsp_valid / rsp_stall / rsp; a transfer happens when valid is high and
// stall is low. Exactly one result is returned per request, in order.
// One request is worked at a time. Insert, delete and membership test run
// a scan of the entry memory that reads one stored id per cycle and, for
// insert and delete, shifts it in the same pass; count query, out-of-range
// banks, full inserts, empty deletes and reads past the count skip the scan,
// and a read entry reads a single stored id.
// A new request is taken in the cycle after the previous result is loaded.
// Reset clears the controller, the result valid and every bank count (through
// per-bank valid bits); entry contents are not cleared and need no sweep.
// While the receiver stalls, the result register holds; the block takes at
// most one more request, works it up to its result and then waits for the
// held result to drain.
`timescale 1ns / 1ps
`default_nettype none

module banked_sorted_id_set import bsis_pkg::*; #(
  parameter int NUM_BANKS     = 16,
  parameter int BANK_CAPACITY = 16,
  parameter int ID_WIDTH      = 32
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      req_valid,
  output logic           req_stall,
  input  wire bsis_req_t req,
  output logic           rsp_valid,
  input  wire logic      rsp_stall,
  output bsis_rsp_t      rsp
);

  bsis_cmd_t cmd;
  bsis_sts_t sts;

  // sequencer
  bsis_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  // storage, scan and result
  bsis_dp #(
    .NUM_BANKS     (NUM_BANKS),
    .BANK_CAPACITY (BANK_CAPACITY),
    .ID_WIDTH      (ID_WIDTH)
  ) u_dp (
    .clk (clk),
    .rst (rst),
    .req (req),
    .cmd (cmd),
    .sts (sts),
    .rsp (rsp)
  );

endmodule

`default_nettype wire

@@ src/bsis_ram.sv @@
// generic simple dual-port ram with registered read
`timescale 1ns / 1ps
`default_nettype none

module bsis_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

@@ src/bsis_ctrl.sv @@
// request sequencer of the banked sorted id set
`timescale 1ns / 1ps
`default_nettype none

module bsis_ctrl import bsis_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      req_valid,
  output logic           req_stall,
  output logic           rsp_valid,
  input  wire logic      rsp_stall,
  output bsis_cmd_t      cmd,
  input  wire bsis_sts_t sts
);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_CNTW  = 5'b00010,
    ST_START = 5'b00100,
    ST_SCAN  = 5'b01000,
    ST_FIN   = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;
  logic   rsp_valid_next;

  assign req_stall = (state != ST_IDLE);

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        if (req_valid) begin
          cmd.capture = 1'b1;
          state_next  = ST_CNTW;
        end
      end
      ST_CNTW: begin
        cmd.load_n = 1'b1;
        state_next = ST_START;
      end
      ST_START: begin
        cmd.start  = 1'b1;
        state_next = ST_SCAN;
      end
      ST_SCAN: begin
        if (!sts.scan_busy) begin
          state_next = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!rsp_valid || !rsp_stall) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // result valid holds until the receiver takes it
  assign rsp_valid_next = cmd.finish | (rsp_valid & rsp_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      rsp_valid <= rsp_valid_next;
    end
  end

endmodule

`default_nettype wire

@@ src/bsis_dp.sv @@
// datapath of the banked sorted id set: entry and count memories, scan, result
`timescale 1ns / 1ps
`default_nettype none

module bsis_dp import bsis_pkg::*; #(
  parameter int NUM_BANKS     = 16,
  parameter int BANK_CAPACITY = 16,
  parameter int ID_WIDTH      = 32
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire bsis_req_t req,
  input  wire bsis_cmd_t cmd,
  output bsis_sts_t      sts,
  output bsis_rsp_t      rsp
);

  localparam int SW    = (ID_WIDTH < 32) ? ID_WIDTH : 32;
  localparam int CW    = $clog2(BANK_CAPACITY + 1);
  localparam int IW    = (BANK_CAPACITY > 1) ? $clog2(BANK_CAPACITY) : 1;
  localparam int BW    = (NUM_BANKS > 1) ? $clog2(NUM_BANKS) : 1;
  localparam int DEPTH = NUM_BANKS * BANK_CAPACITY;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int XW    = (CW > 4) ? CW : 4;

  bsis_req_t             rq;
  logic                  bank_ok;
  logic [BW-1:0]         bidx;
  logic [BW-1:0]         cnt_raddr;
  logic [CW-1:0]         cnt_rdata;
  logic [CW-1:0]         n;
  logic [NUM_BANKS-1:0]  valid_bits;
  logic [SW-1:0]         id_s;
  logic [AW-1:0]         base;

  logic                  iss_act;
  logic [IW-1:0]         ptr;
  logic [IW-1:0]         last;
  logic                  dir_up;
  logic                  dvld;
  logic [IW-1:0]         didx;
  logic                  hit;
  logic                  term;
  logic                  put_pend;
  logic                  ok_r;
  logic [SW-1:0]         value;
  logic [SW-1:0]         rdata;

  logic                  full;
  logic [XW-1:0]         n_x;
  logic [XW-1:0]         idx_x;
  logic [IW-1:0]         n_last;
  logic                  start_scan;
  logic                  start_put;
  logic                  ins_shift;
  logic                  ins_place;
  logic                  del_shift;
  logic                  hit_now;
  logic                  wr_en;
  logic [IW-1:0]         wr_idx;
  logic [SW-1:0]         wr_data;
  logic                  fin_ok;
  logic [CW-1:0]         n_fin;

  // bank decode and request fields
  assign bank_ok   = (rq.bank != 5'd0) && ({4'b0, rq.bank} <= 9'(NUM_BANKS));
  assign bidx      = BW'(rq.bank - 5'd1);
  assign cnt_raddr = BW'(req.bank - 5'd1);
  assign id_s      = SW'(rq.item_id);
  assign base      = AW'(AW'(bidx) * AW'(BANK_CAPACITY));

  // per-bank fill counts
  bsis_ram #(.WIDTH(CW), .DEPTH(NUM_BANKS)) u_cnt_ram (
    .clk     (clk),
    .wr_en   (cmd.finish & bank_ok),
    .wr_addr (bidx),
    .wr_data (n_fin),
    .rd_en   (cmd.capture),
    .rd_addr (cnt_raddr),
    .rd_data (cnt_rdata)
  );

  // sorted entries, one window of BANK_CAPACITY per bank
  bsis_ram #(.WIDTH(SW), .DEPTH(DEPTH)) u_entry_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (AW'(base + AW'(wr_idx))),
    .wr_data (wr_data),
    .rd_en   (iss_act),
    .rd_addr (AW'(base + AW'(ptr))),
    .rd_data (rdata)
  );

  // scan setup decisions
  assign full       = (n == CW'(BANK_CAPACITY));
  assign n_x        = XW'(n);
  assign idx_x      = XW'(rq.entry_index);
  assign n_last     = IW'(n - 1'b1);
  assign start_scan = bank_ok &&
                      (((rq.op == OP_INSERT) && !full && (n != '0)) ||
                       ((rq.op inside {OP_DELETE, OP_TEST}) && (n != '0)) ||
                       ((rq.op == OP_READ) && (idx_x < n_x)));
  assign start_put  = bank_ok && (rq.op == OP_INSERT) && !full && (n == '0);

  // actions on returning read data
  assign ins_shift = dvld && (rq.op == OP_INSERT) && !term && (rdata >= id_s);
  assign ins_place = dvld && (rq.op == OP_INSERT) && !term && (rdata < id_s);
  assign del_shift = dvld && (rq.op == OP_DELETE) && hit;
  assign hit_now   = dvld && (rq.op inside {OP_DELETE, OP_TEST}) && !hit && (rdata == id_s);

  // entry write selection
  always_comb begin
    wr_en   = 1'b0;
    wr_idx  = '0;
    wr_data = rdata;
    if (put_pend) begin
      wr_en   = 1'b1;
      wr_data = id_s;
    end else if (ins_shift) begin
      wr_en  = 1'b1;
      wr_idx = IW'(didx + 1'b1);
    end else if (ins_place) begin
      wr_en   = 1'b1;
      wr_idx  = IW'(didx + 1'b1);
      wr_data = id_s;
    end else if (del_shift) begin
      wr_en  = 1'b1;
      wr_idx = IW'(didx - 1'b1);
    end
  end

  assign sts.scan_busy = iss_act | dvld | put_pend;

  // final result of the request
  always_comb begin
    case (rq.op)
      OP_INSERT, OP_READ, OP_COUNT: fin_ok = ok_r;
      OP_DELETE, OP_TEST:           fin_ok = hit;
      default:                      fin_ok = 1'b0;
    endcase
    if ((rq.op == OP_INSERT) && ok_r) begin
      n_fin = CW'(n + 1'b1);
    end else if ((rq.op == OP_DELETE) && hit) begin
      n_fin = CW'(n - 1'b1);
    end else begin
      n_fin = n;
    end
  end

  // scan control and count valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      iss_act    <= 1'b0;
      dvld       <= 1'b0;
      put_pend   <= 1'b0;
      valid_bits <= '0;
    end else begin
      if (cmd.start) begin
        iss_act  <= start_scan;
        dvld     <= 1'b0;
        put_pend <= start_put;
      end else begin
        iss_act  <= iss_act && (ptr != last) && !ins_place;
        dvld     <= iss_act;
        put_pend <= ins_shift && (didx == '0);
      end
      if (cmd.finish && bank_ok) begin
        valid_bits[bidx] <= 1'b1;
      end
    end
  end

  // request, scan payload and result registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      rq <= req;
    end
    if (cmd.load_n) begin
      n <= valid_bits[bidx] ? cnt_rdata : '0;
    end
    didx <= ptr;
    if (cmd.start) begin
      hit   <= 1'b0;
      term  <= 1'b0;
      value <= '0;
      case (rq.op)
        OP_INSERT: begin
          ok_r   <= !full;
          ptr    <= n_last;
          last   <= '0;
          dir_up <= 1'b0;
        end
        OP_READ: begin
          ok_r   <= (idx_x < n_x);
          ptr    <= IW'(idx_x);
          last   <= IW'(idx_x);
          dir_up <= 1'b1;
        end
        OP_COUNT: begin
          ok_r   <= 1'b1;
          ptr    <= '0;
          last   <= n_last;
          dir_up <= 1'b1;
        end
        default: begin
          ok_r   <= 1'b0;
          ptr    <= '0;
          last   <= n_last;
          dir_up <= 1'b1;
        end
      endcase
    end else begin
      if (iss_act && (ptr != last)) begin
        ptr <= dir_up ? IW'(ptr + 1'b1) : IW'(ptr - 1'b1);
      end
      if (hit_now) begin
        hit <= 1'b1;
      end
      if (ins_place) begin
        term <= 1'b1;
      end
      if (dvld && (rq.op == OP_READ)) begin
        value <= rdata;
      end
    end
    if (cmd.finish) begin
      rsp.ok          <= bank_ok & fin_ok;
      rsp.held_count  <= bank_ok ? 5'(n_fin) : 5'd0;
      rsp.entry_value <= bank_ok ? 32'(value) : 32'd0;
    end
  end

endmodule

`default_nettype wire
